>>> rtl/ssb_pkg.sv
// shared types and constants for the server selection balancer
// used by ssb_cell, ssb_table and server_selection_balancer
package ssb_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int MAX_CLIENTS = 64;
  localparam int SIDX = $clog2(MAX_SERVERS);
  localparam int SCNT = $clog2(MAX_SERVERS + 1);
  localparam int CIDX = $clog2(MAX_CLIENTS);
  localparam int CCNT = $clog2(MAX_CLIENTS + 1);

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_REMOVE = 2'd1,
    FN_REQUEST = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    POL_RR = 2'd0,
    POL_WRR = 2'd1,
    POL_AFFINITY = 2'd2,
    POL_LEAST = 2'd3
  } policy_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_MAPFULL = 3'd2;
  localparam logic [2:0] ST_DUP = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_SHIFT,
    OP_INC
  } op_t;

  typedef struct packed {
    op_t op;
    logic [SIDX-1:0] idx;
  } tbl_cmd_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0] weight;
    logic [15:0] load;
  } ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic use_port;
  } key_t;

  // search token walking down the chain
  typedef struct packed {
    logic hit;
    logic [SIDX-1:0] hit_idx;
    logic [15:0] min_load;
    logic [SIDX-1:0] min_idx;
  } tok_t;

  typedef struct packed {
    logic [31:0] client;
    logic [31:0] ip;
    logic [15:0] port;
  } cmap_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRR,
    S_CSCAN,
    S_AFFW,
    S_FIN
  } state_t;

endpackage

>>> rtl/ssb_cell.sv
// one server slot of the table chain: holds an entry and passes the search token on
// depends on ssb_pkg
module ssb_cell (
  input  logic                    clk,
  input  logic [ssb_pkg::SIDX-1:0] idx,
  input  logic [ssb_pkg::SCNT-1:0] count,
  input  ssb_pkg::key_t           key,
  input  ssb_pkg::tbl_cmd_t       cmd,
  input  ssb_pkg::ent_t           wdata,
  input  ssb_pkg::ent_t           nbr,
  input  ssb_pkg::tok_t           tok_in,
  output ssb_pkg::tok_t           tok_out,
  output ssb_pkg::ent_t           ent
);
  import ssb_pkg::*;

  logic active;
  logic match;
  tok_t tok_next;

  assign active = SCNT'(idx) < count;
  assign match = (ent.ip == key.ip) && (!key.use_port || (ent.port == key.port));

  always_comb begin
    tok_next = tok_in;
    if (active && match && !tok_in.hit) begin
      tok_next.hit = 1'b1;
      tok_next.hit_idx = idx;
    end
    if (active && (ent.load < tok_in.min_load)) begin
      tok_next.min_load = ent.load;
      tok_next.min_idx = idx;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    case (cmd.op)
      OP_WRITE: begin
        if (cmd.idx == idx) ent <= wdata;
      end
      OP_SHIFT: begin
        // close the gap left by a removed entry
        if (idx >= cmd.idx) ent <= nbr;
      end
      OP_INC: begin
        if ((cmd.idx == idx) && (ent.load != 16'hFFFF)) ent.load <= ent.load + 16'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/ssb_table.sv
// server table: row of ssb_cell slots with a search token chain and a read mux
// depends on ssb_pkg and ssb_cell
module ssb_table (
  input  logic                    clk,
  input  logic [ssb_pkg::SCNT-1:0] count,
  input  ssb_pkg::key_t           key,
  input  ssb_pkg::tbl_cmd_t       cmd,
  input  ssb_pkg::ent_t           wdata,
  input  logic [ssb_pkg::SIDX-1:0] rd_idx,
  output ssb_pkg::tok_t           tok,
  output ssb_pkg::ent_t           rd_ent
);
  import ssb_pkg::*;

  tok_t tok_w [MAX_SERVERS+1];
  ent_t ent_w [MAX_SERVERS];

  assign tok_w[0] = '{hit: 1'b0, hit_idx: '0, min_load: 16'hFFFF, min_idx: '0};

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    ent_t nbr;
    if (i < MAX_SERVERS - 1) begin : g_mid
      assign nbr = ent_w[i+1];
    end else begin : g_last
      assign nbr = ent_w[i];
    end
    ssb_cell u_cell (
      .clk    (clk),
      .idx    (SIDX'(i)),
      .count  (count),
      .key    (key),
      .cmd    (cmd),
      .wdata  (wdata),
      .nbr    (nbr),
      .tok_in (tok_w[i]),
      .tok_out(tok_w[i+1]),
      .ent    (ent_w[i])
    );
  end

  assign tok = tok_w[MAX_SERVERS];
  assign rd_ent = ent_w[rd_idx];

endmodule

>>> rtl/server_selection_balancer.sv
// server selection balancer top level: request sequencer, client map memory
// depends on ssb_pkg and ssb_table
//
// usage:
//   input channel (in_valid/in_stall) carries one request: func, server fields,
//   client_addr. add and remove look for the server, client requests pick one by
//   the policy register (cfg_wr_en/cfg_wr_data); the user must write it only
//   while idle, the block does not enforce this. output channel (out_valid/
//   out_stall) returns status, chosen_ip, chosen_port for every request;
//   address and port are 0 unless status is ok.
// request flow:
//   one request at a time. round robin, an empty table and an unused func go
//   straight to the result; weighted round robin first takes its weight step.
//   add, remove and least load pass a search token down the 16-slot cell chain.
//   client affinity reads the 64-entry client map one entry per cycle through
//   its single read port and adds a missed client if the map has room. the next
//   request can be taken in the cycle after the result is loaded.
// reset clears the counts, positions, policy and output valid; table and map
// contents are only read below their counts, so they are not cleared.
// a stalled result holds the output; the next request may still be taken and
// worked on, but it waits in its last state until the output frees.
module server_selection_balancer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] server_ip,
  input  logic [15:0] srv_port,
  input  logic [7:0]  server_weight,
  input  logic [15:0] initial_load,
  input  logic [31:0] client_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] chosen_ip,
  output logic [15:0] chosen_port
);
  import ssb_pkg::*;

  state_t state, state_next;
  policy_t policy;
  func_t func_r;
  key_t key;
  logic [7:0] wt;
  logic [15:0] ld;
  logic [31:0] cip;
  logic [SCNT-1:0] scount;
  logic [SIDX-1:0] rr, wpos, apos, rd_idx;
  logic [7:0] wrun;
  logic [CCNT-1:0] ccount, ci;
  logic [SCNT-1:0] scan_cnt;
  logic rd_pend;
  logic from_tbl;
  logic [2:0] res_status;
  logic [31:0] res_ip;
  logic [15:0] res_port;

  tbl_cmd_t tbl_cmd;
  ent_t wdata, rd_ent;
  tok_t tok;

  cmap_t cmap [MAX_CLIENTS];
  cmap_t mem_q;
  logic mem_we;

  logic scan_done, accept, out_load, cl_hit, cl_issue, cl_miss;

  function automatic logic [SIDX-1:0] wrap_pos(logic [SIDX-1:0] p, logic [SCNT-1:0] n);
    return (SCNT'(p) < n) ? p : '0;
  endfunction

  function automatic logic [SIDX-1:0] next_pos(logic [SIDX-1:0] p, logic [SCNT-1:0] n);
    return ((SCNT'(p) + SCNT'(1)) < n) ? SIDX'(SCNT'(p) + SCNT'(1)) : '0;
  endfunction

  ssb_table u_table (
    .clk   (clk),
    .count (scount),
    .key   (key),
    .cmd   (tbl_cmd),
    .wdata (wdata),
    .rd_idx(rd_idx),
    .tok   (tok),
    .rd_ent(rd_ent)
  );

  assign wdata = '{ip: key.ip, port: key.port, weight: wt, load: ld};
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign scan_done = (state == S_SCAN) && (scan_cnt == SCNT'(MAX_SERVERS));
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);
  assign cl_hit = rd_pend && (mem_q.client == cip);
  assign cl_issue = !cl_hit && (ci < ccount);
  assign cl_miss = !cl_hit && !cl_issue && !rd_pend;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    tbl_cmd = '{op: OP_NOP, idx: '0};
    mem_we = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (func_t'(func) == FN_ADD || func_t'(func) == FN_REMOVE) state_next = S_SCAN;
          else if (func_t'(func) == FN_REQUEST && scount != '0) begin
            case (policy)
              POL_WRR: state_next = S_WRR;
              POL_AFFINITY: state_next = S_CSCAN;
              POL_LEAST: state_next = S_SCAN;
              default: state_next = S_FIN;
            endcase
          end else state_next = S_FIN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FIN;
          case (func_r)
            FN_ADD: begin
              if (!tok.hit && scount < SCNT'(MAX_SERVERS))
                tbl_cmd = '{op: OP_WRITE, idx: scount[SIDX-1:0]};
            end
            FN_REMOVE: begin
              if (tok.hit) tbl_cmd = '{op: OP_SHIFT, idx: tok.hit_idx};
            end
            default: tbl_cmd = '{op: OP_INC, idx: tok.min_idx};
          endcase
        end
      end
      S_WRR: state_next = S_FIN;
      S_CSCAN: begin
        if (cl_hit) state_next = S_FIN;
        else if (cl_miss) state_next = (ccount >= CCNT'(MAX_CLIENTS)) ? S_FIN : S_AFFW;
      end
      S_AFFW: begin
        mem_we = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // client map, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) cmap[ccount[CIDX-1:0]] <= '{client: cip, ip: rd_ent.ip, port: rd_ent.port};
    mem_q <= cmap[ci[CIDX-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_RR;
      scount <= '0;
      rr <= '0;
      wpos <= '0;
      wrun <= '0;
      apos <= '0;
      ccount <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) policy <= policy_t'(cfg_wr_data);
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_r <= func_t'(func);
            key <= '{ip: server_ip, port: srv_port,
                     use_port: (func_t'(func) == FN_ADD)};
            wt <= server_weight;
            ld <= initial_load;
            cip <= client_addr;
            scan_cnt <= '0;
            ci <= '0;
            rd_pend <= 1'b0;
            from_tbl <= (func_t'(func) == FN_REQUEST) && (scount != '0) &&
                        (policy == POL_RR);
            res_status <= ((func_t'(func) == FN_REQUEST) && (scount == '0)) ?
                          ST_EMPTY : ST_OK;
            res_ip <= '0;
            res_port <= '0;
            if (func_t'(func) == FN_REQUEST && scount != '0) begin
              case (policy)
                POL_RR: begin
                  rd_idx <= wrap_pos(rr, scount);
                  rr <= next_pos(wrap_pos(rr, scount), scount);
                end
                POL_WRR: rd_idx <= wrap_pos(wpos, scount);
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCNT'(1);
          if (scan_done) begin
            case (func_r)
              FN_ADD: begin
                if (tok.hit) res_status <= ST_DUP;
                else if (scount >= SCNT'(MAX_SERVERS)) res_status <= ST_FULL;
                else scount <= scount + SCNT'(1);
              end
              FN_REMOVE: begin
                if (tok.hit) scount <= scount - SCNT'(1);
                else res_status <= ST_NOTFOUND;
              end
              default: begin
                rd_idx <= tok.min_idx;
                from_tbl <= 1'b1;
              end
            endcase
          end
        end
        S_WRR: begin
          from_tbl <= 1'b1;
          if (wrun < rd_ent.weight) begin
            wrun <= wrun + 8'd1;
            wpos <= rd_idx;
          end else begin
            wrun <= 8'd1;
            wpos <= next_pos(rd_idx, scount);
            rd_idx <= next_pos(rd_idx, scount);
          end
        end
        S_CSCAN: begin
          rd_pend <= cl_issue;
          if (cl_issue) ci <= ci + CCNT'(1);
          if (cl_hit) begin
            res_ip <= mem_q.ip;
            res_port <= mem_q.port;
          end else if (cl_miss) begin
            if (ccount >= CCNT'(MAX_CLIENTS)) res_status <= ST_MAPFULL;
            else rd_idx <= wrap_pos(apos, scount);
          end
        end
        S_AFFW: begin
          ccount <= ccount + CCNT'(1);
          apos <= next_pos(rd_idx, scount);
          from_tbl <= 1'b1;
        end
        S_FIN: begin
          if (out_load) begin
            status <= res_status;
            if (res_status != ST_OK) begin
              chosen_ip <= '0;
              chosen_port <= '0;
            end else if (from_tbl) begin
              chosen_ip <= rd_ent.ip;
              chosen_port <= rd_ent.port;
            end else begin
              chosen_ip <= res_ip;
              chosen_port <= res_port;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_scount_range: assert property (@(posedge clk) disable iff (rst)
    scount <= SCNT'(MAX_SERVERS)) else $error("server count out of range");

  a_ccount_range: assert property (@(posedge clk) disable iff (rst)
    ccount <= CCNT'(MAX_CLIENTS)) else $error("client count out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> chosen_ip == '0 && chosen_port == '0)
    else $error("failed request carries an address");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_cnt <= SCNT'(MAX_SERVERS)) else $error("scan overrun");

endmodule
